// ----- rtl/bce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants of the battery charge estimator: the voltage
// knee table, per-segment slope and reciprocal constants, register indexes.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FALLBACK_LOW  = 2'd0,
        REG_FALLBACK_HIGH = 2'd1
    } reg_index_t;

    localparam int          TablePoints  = 11;
    localparam int          Segments     = TablePoints - 1;
    localparam int          SegW         = 4;
    localparam int          DvW          = 9;   // widest span is 300 mV
    localparam int          DpW          = 4;   // steepest segment rises 15 %
    localparam int          ProdW        = DvW + DpW;
    localparam int          RecipW       = 19;
    localparam int          RecipShift   = 24;
    localparam int          QuotW        = 4;
    localparam int          ScaledW      = ProdW + RecipW;

    localparam logic [15:0] FallbackLowReset  = 16'd3000;
    localparam logic [15:0] FallbackHighReset = 16'd4050;
    localparam logic [15:0] FullPercent       = 16'd100;
    localparam logic [7:0]  FullPct8          = 8'd100;
    localparam logic [7:0]  EmptyPct8         = 8'd0;
    localparam logic [7:0]  UnavailPct8       = 8'hFF;

    // Knee voltages and charge at each knee
    localparam logic [15:0] KNEE_MV [0:TablePoints-1] = '{
        16'd3300, 16'd3600, 16'd3700, 16'd3750, 16'd3800, 16'd3850,
        16'd3900, 16'd3950, 16'd4000, 16'd4100, 16'd4200
    };
    localparam logic [7:0] KNEE_PCT [0:TablePoints-1] = '{
        8'd0, 8'd8, 8'd20, 8'd35, 8'd50, 8'd62,
        8'd72, 8'd80, 8'd88, 8'd96, 8'd100
    };

    // Percent rise over each segment
    localparam logic [DpW-1:0] SEG_DP [0:Segments-1] = '{
        4'd8, 4'd12, 4'd15, 4'd15, 4'd12, 4'd10, 4'd8, 4'd8, 4'd8, 4'd4
    };

    // ceil(2^24 / span) per segment; spans are 300, 100 and 50 mV.
    // Exact floor division for any product below 2^13.
    localparam logic [RecipW-1:0] SEG_RECIP [0:Segments-1] = '{
        19'd55925,  19'd167773, 19'd335545, 19'd335545, 19'd335545,
        19'd335545, 19'd335545, 19'd335545, 19'd167773, 19'd167773
    };

    // Interpolation request into the divide pipeline
    typedef struct packed {
        logic [DvW-1:0]  dv;
        logic [SegW-1:0] seg;
    } interp_req_t;

    // Payload carried alongside the interpolation pipeline
    typedef struct packed {
        logic [7:0]         base_pct;
        logic [15:0]        voltage;
        logic signed [15:0] current;
        logic               charging;
        logic               changed;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/bce_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bce_interp
// Two-stage interpolation datapath: slope multiply, then division by the
// segment span through a reciprocal multiply. Advances on en only.
// ----------------------------------------------------------------------------
module bce_interp (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire bce_pkg::interp_req_t       req,
    output logic [bce_pkg::QuotW-1:0]       quot
);

    logic [bce_pkg::ProdW-1:0]   prod_reg;
    logic [bce_pkg::ProdW-1:0]   prod_next;
    logic [bce_pkg::SegW-1:0]    seg_reg;
    logic [bce_pkg::ScaledW-1:0] scaled_reg;
    logic [bce_pkg::ScaledW-1:0] scaled_next;

    // Multiply offset into the segment by the segment's percent rise
    always_comb
    begin
        prod_next = bce_pkg::ProdW'(req.dv) * bce_pkg::ProdW'(bce_pkg::SEG_DP[req.seg]);
    end

    // Divide by the span: multiply by the scaled reciprocal
    always_comb
    begin
        scaled_next = bce_pkg::ScaledW'(prod_reg)
                    * bce_pkg::ScaledW'(bce_pkg::SEG_RECIP[seg_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            seg_reg    <= req.seg;
            scaled_reg <= scaled_next;
        end
    end

    assign quot = scaled_reg[bce_pkg::RecipShift +: bce_pkg::QuotW];

endmodule

`default_nettype wire

// ----- rtl/battery_charge_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_charge_estimator
// Turns one fuel-gauge poll into a charge percent, replacing a stuck 100 %
// by a piecewise-linear voltage estimate, and tracks the held cell state.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_stall    | read_ok, gauge_percent, cell_voltage_mv,
//          |                        | cell_current_ma
//  out     | out_valid / out_stall  | charge_percent, held_voltage_mv,
//          |                        | held_current_ma, is_charging, changed_event
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// Four register stages (decode, slope multiply, reciprocal multiply, sum);
// a poll passes through them in order, one poll per cycle while the output is not stalled.
// The two multipliers in bce_interp set the stage depth.
// Held voltage, current and charging update in poll order at the decode stage.
// A stalled output freezes every stage; in_stall follows from it.
// Reset clears valid bits, held state and loads the window registers.
// ----------------------------------------------------------------------------
module battery_charge_estimator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               read_ok,
    input  wire logic [15:0]        gauge_percent,
    input  wire logic [15:0]        cell_voltage_mv,
    input  wire logic signed [15:0] cell_current_ma,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [7:0]       charge_percent,
    output logic [15:0]             held_voltage_mv,
    output logic signed [15:0]      held_current_ma,
    output logic                    is_charging,
    output logic                    changed_event,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    logic                          adv;
    logic                          take;
    logic [15:0]                   fb_low_reg;
    logic [15:0]                   fb_high_reg;
    logic [15:0]                   held_v_reg;
    logic signed [15:0]            held_i_reg;
    logic                          held_chg_reg;
    logic [2:0]                    valid_reg;
    logic [2:0]                    valid_next;
    bce_pkg::side_t                side1_reg;
    bce_pkg::side_t                side2_reg;
    bce_pkg::side_t                side3_reg;
    bce_pkg::side_t                side_next;
    bce_pkg::interp_req_t          req_reg;
    bce_pkg::interp_req_t          req_next;
    logic [bce_pkg::QuotW-1:0]     quot;
    logic                          out_valid_reg;
    logic [7:0]                    pct_reg;
    logic [7:0]                    pct_next;
    logic [15:0]                   out_v_reg;
    logic signed [15:0]            out_i_reg;
    logic                          out_chg_reg;
    logic                          out_changed_reg;
    logic                          charging;
    logic                          use_fallback;
    logic [bce_pkg::SegW-1:0]      seg;
    logic [7:0]                    clamped;

    // Advance the whole pipeline unless the output is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_low_reg  <= bce_pkg::FallbackLowReset;
            fb_high_reg <= bce_pkg::FallbackHighReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bce_pkg::REG_FALLBACK_LOW:  fb_low_reg  <= cfg_data;
                bce_pkg::REG_FALLBACK_HIGH: fb_high_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Decode the poll: clamp, charging flag, window test, segment search
    always_comb
    begin
        charging     = !cell_current_ma[15] && (cell_current_ma != 16'sd0);
        clamped      = (gauge_percent > bce_pkg::FullPercent) ? bce_pkg::FullPct8
                                                              : gauge_percent[7:0];
        use_fallback = (cell_voltage_mv >= fb_low_reg) && (cell_voltage_mv < fb_high_reg)
                    && (gauge_percent >= bce_pkg::FullPercent) && !charging;
        seg = '0;
        for (int j = bce_pkg::Segments - 1; j >= 0; j--)
        begin
            if (cell_voltage_mv < bce_pkg::KNEE_MV[j + 1])
            begin
                seg = bce_pkg::SegW'(j);
            end
        end

        req_next.seg = seg;
        req_next.dv  = '0;
        side_next.base_pct = clamped;
        if (!read_ok)
        begin
            side_next.base_pct = bce_pkg::UnavailPct8;
        end
        else if (use_fallback)
        begin
            if (cell_voltage_mv <= bce_pkg::KNEE_MV[0])
            begin
                side_next.base_pct = bce_pkg::EmptyPct8;
            end
            else if (cell_voltage_mv >= bce_pkg::KNEE_MV[bce_pkg::TablePoints - 1])
            begin
                side_next.base_pct = bce_pkg::FullPct8;
            end
            else
            begin
                side_next.base_pct = bce_pkg::KNEE_PCT[seg];
                req_next.dv = bce_pkg::DvW'(cell_voltage_mv - bce_pkg::KNEE_MV[seg]);
            end
        end

        side_next.voltage  = read_ok ? cell_voltage_mv : held_v_reg;
        side_next.current  = read_ok ? cell_current_ma : held_i_reg;
        side_next.charging = read_ok ? charging : held_chg_reg;
        side_next.changed  = read_ok;
    end

    // Update held cell state in poll order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg   <= '0;
            held_i_reg   <= '0;
            held_chg_reg <= 1'b0;
        end
        else if (take && read_ok)
        begin
            held_v_reg   <= cell_voltage_mv;
            held_i_reg   <= cell_current_ma;
            held_chg_reg <= charging;
        end
    end

    // Advance valid bits
    always_comb
    begin
        valid_next = {valid_reg[1:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[2];
        end
    end

    // Advance side payload alongside the interpolation stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side_next;
            req_reg   <= req_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    bce_interp u_interp (
        .clk  (clk),
        .en   (adv),
        .req  (req_reg),
        .quot (quot)
    );

    // Sum base percent and interpolated step into the output register
    always_comb
    begin
        pct_next = side3_reg.base_pct + 8'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pct_reg         <= pct_next;
            out_v_reg       <= side3_reg.voltage;
            out_i_reg       <= side3_reg.current;
            out_chg_reg     <= side3_reg.charging;
            out_changed_reg <= side3_reg.changed;
        end
    end

    assign out_valid       = out_valid_reg;
    assign charge_percent  = $signed(pct_reg);
    assign held_voltage_mv = out_v_reg;
    assign held_current_ma = out_i_reg;
    assign is_charging     = out_chg_reg;
    assign changed_event   = out_changed_reg;

    // A failed read always reports unavailable
    a_fail_pct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !changed_event |-> charge_percent == -8'sd1)
        else $error("failed read did not report -1");

    // A good read stays within 0..100
    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed_event |-> (charge_percent >= 8'sd0)
                                       && (charge_percent <= 8'sd100))
        else $error("good read percent out of range");

    // A good read transfer captures the cell voltage into the held state
    a_held_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && read_ok |=> held_v_reg == $past(cell_voltage_mv))
        else $error("held voltage not captured");

endmodule

`default_nettype wire

// ----- tb/battery_charge_estimator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_estimator_tb
// Drives fuel-gauge polls through the charge estimator and checks every
// report against an in-bench prediction of the percent and the held cell state.
// ----------------------------------------------------------------------------
module battery_charge_estimator_tb;

    localparam int          KneeCount    = 11;
    localparam int          PipeDepth    = 4;
    localparam int          SettleCycles = 2 * PipeDepth;
    localparam int          DrainLimit   = 20000;
    localparam int          RandomPolls  = 2000;
    localparam logic [1:0]  RegSpareA    = 2'd2;
    localparam logic [1:0]  RegSpareB    = 2'd3;
    localparam logic [15:0] FullPct      = 16'd100;
    localparam logic [7:0]  NoReadPct    = 8'hFF;

    // Discharge curve: knee voltage and charge at that knee
    localparam logic [15:0] KneeVolt [0:KneeCount-1] = '{
        16'd3300, 16'd3600, 16'd3700, 16'd3750, 16'd3800, 16'd3850,
        16'd3900, 16'd3950, 16'd4000, 16'd4100, 16'd4200
    };
    localparam int KneePct [0:KneeCount-1] = '{
        0, 8, 20, 35, 50, 62, 72, 80, 88, 96, 100
    };

    typedef struct packed {
        logic               ok;
        logic [15:0]        pct;
        logic [15:0]        mv;
        logic signed [15:0] cur;
    } gauge_poll_t;

    typedef struct packed {
        logic signed [7:0]  pct;
        logic [15:0]        mv;
        logic signed [15:0] cur;
        logic               chg;
        logic               evt;
    } charge_report_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               read_ok;
    logic [15:0]        gauge_percent;
    logic [15:0]        cell_voltage_mv;
    logic signed [15:0] cell_current_ma;
    logic               out_valid;
    logic               out_stall;
    logic signed [7:0]  charge_percent;
    logic [15:0]        held_voltage_mv;
    logic signed [15:0] held_current_ma;
    logic               is_charging;
    logic               changed_event;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Shadow of the block's registers and held cell state
    logic [15:0]        window_low;
    logic [15:0]        window_high;
    logic [15:0]        held_mv;
    logic signed [15:0] held_ma;
    logic               held_chg;

    charge_report_t     expected_reports[$];
    int                 mismatch_count;
    bit                 idle_en;
    int                 hold_off_req;

    battery_charge_estimator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .read_ok         (read_ok),
        .gauge_percent   (gauge_percent),
        .cell_voltage_mv (cell_voltage_mv),
        .cell_current_ma (cell_current_ma),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .charge_percent  (charge_percent),
        .held_voltage_mv (held_voltage_mv),
        .held_current_ma (held_current_ma),
        .is_charging     (is_charging),
        .changed_event   (changed_event),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Piecewise-linear charge from voltage, truncating division
    function automatic logic [7:0] voltage_to_percent(input logic [15:0] mv);
        int seg;
        int est;
        if (mv <= KneeVolt[0])
            return 8'd0;
        if (mv >= KneeVolt[KneeCount-1])
            return 8'd100;
        est = 100;
        for (seg = 1; seg < KneeCount; seg++)
        begin
            if (mv < KneeVolt[seg])
            begin
                est = KneePct[seg-1]
                    + ((int'(mv) - int'(KneeVolt[seg-1])) * (KneePct[seg] - KneePct[seg-1]))
                    / (int'(KneeVolt[seg]) - int'(KneeVolt[seg-1]));
                break;
            end
        end
        return est[7:0];
    endfunction

    // Work out the report for one poll and advance the held state
    function automatic charge_report_t predict_poll(input gauge_poll_t p);
        charge_report_t r;
        logic [15:0]    pct;
        logic           chg;
        r.evt = 1'b0;
        r.pct = NoReadPct;
        if (p.ok)
        begin
            pct = (p.pct > FullPct) ? FullPct : p.pct;
            chg = (p.cur > 0);
            held_mv  = p.mv;
            held_ma  = p.cur;
            held_chg = chg;
            if (p.mv >= window_low && p.mv < window_high && p.pct >= FullPct && !chg)
                pct = {8'd0, voltage_to_percent(p.mv)};
            r.pct = pct[7:0];
            r.evt = 1'b1;
        end
        r.mv  = held_mv;
        r.cur = held_ma;
        r.chg = held_chg;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one poll, hold it until the transfer, record the prediction
    task automatic send_poll(input gauge_poll_t p);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        read_ok         <= p.ok;
        gauge_percent   <= p.pct;
        cell_voltage_mv <= p.mv;
        cell_current_ma <= p.cur;
        do
            @(posedge clk);
        while (in_stall);
        expected_reports.push_back(predict_poll(p));
    endtask

    task automatic poll(input logic ok, input logic [15:0] pct, input logic [15:0] mv,
                        input logic signed [15:0] cur);
        send_poll('{ok: ok, pct: pct, mv: mv, cur: cur});
    endtask

    // Drop valid and hold until every report has come back
    task automatic wait_for_reports();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (expected_reports.size() != 0 && guard < DrainLimit)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_reports.size() != 0)
        begin
            $display("%0t: %0d reports never arrived", $time, expected_reports.size());
            mismatch_count++;
            expected_reports.delete();
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Write one window register; the block must be idle
    task automatic write_window_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bce_pkg::REG_FALLBACK_LOW)
            window_low = value;
        else if (idx == bce_pkg::REG_FALLBACK_HIGH)
            window_high = value;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [15:0] low, input logic [15:0] high);
        wait_for_reports();
        write_window_reg(bce_pkg::REG_FALLBACK_LOW, low);
        write_window_reg(bce_pkg::REG_FALLBACK_HIGH, high);
    endtask

    function automatic gauge_poll_t random_poll();
        gauge_poll_t p;
        p.ok = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
            0:       p.pct = FullPct;
            1:       p.pct = 16'($urandom_range(101, 65535));
            2:       p.pct = 16'($urandom_range(0, 100));
            default: p.pct = 16'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0, 1:    p.mv = 16'($urandom_range(3250, 4250));
            2:       p.mv = 16'($urandom_range(2900, 4400));
            default: p.mv = 16'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0:       p.cur = 16'sd0;
            1:       p.cur = 16'($urandom_range(1, 500));
            2:       p.cur = -16'($urandom_range(1, 2000));
            default: p.cur = 16'($urandom());
        endcase
        return p;
    endfunction

    // Pick a window: default, wide open, empty, inverted or random
    task automatic random_window();
        logic [15:0] lo;
        lo = 16'($urandom());
        case ($urandom_range(0, 5))
            0: set_window(16'd3000, 16'd4050);
            1: set_window(16'd0, 16'hFFFF);
            2: set_window(lo, lo);
            3: set_window(16'hFFFF, 16'd0);
            4:
            begin
                lo = 16'($urandom_range(3200, 4200));
                set_window(lo, 16'($urandom_range(lo, 4300)));
            end
            default: set_window(lo, 16'($urandom()));
        endcase
    endtask

    // Extremes of every field, the lowest table edge, the window edges and the failed-read path
    task automatic test_directed();
        poll(1'b0, 16'd55, 16'd3700, 16'sd10);
        poll(1'b1, 16'd0, 16'd0, 16'sd0);
        poll(1'b1, 16'd100, 16'd2999, 16'sd0);
        poll(1'b1, 16'd100, 16'd3000, 16'sd0);
        poll(1'b1, 16'd100, 16'd3299, -16'sd1);
        poll(1'b1, 16'd100, 16'd3300, -16'sd32768);
        poll(1'b1, 16'd100, 16'd3301, 16'sd0);
        poll(1'b1, 16'd101, 16'd3600, 16'sd0);
        poll(1'b1, 16'hFFFF, 16'd3650, 16'sd0);
        poll(1'b1, 16'd100, 16'd3725, 16'sd0);
        poll(1'b1, 16'd100, 16'd3775, 16'sd0);
        poll(1'b1, 16'd100, 16'd3849, 16'sd0);
        poll(1'b1, 16'd100, 16'd3899, 16'sd0);
        poll(1'b1, 16'd100, 16'd3950, 16'sd0);
        poll(1'b1, 16'd100, 16'd4049, 16'sd0);
        poll(1'b1, 16'd100, 16'd4050, 16'sd0);
        poll(1'b1, 16'd100, 16'd3800, 16'sd1);
        poll(1'b1, 16'd200, 16'd3800, 16'sd32767);
        poll(1'b1, 16'd99, 16'd3800, 16'sd0);
        poll(1'b1, 16'd50, 16'hFFFF, -16'sd5);
        poll(1'b0, 16'hFFFF, 16'hFFFF, -16'sd32768);
        poll(1'b0, 16'd0, 16'd0, 16'sd0);
        poll(1'b1, 16'h8000, 16'h8000, 16'sh5555);
        poll(1'b1, 16'h7FFF, 16'h7FFF, 16'shAAAA);
        wait_for_reports();
    endtask

    // Window extremes, empty and inverted windows, spare indexes ignored
    task automatic test_window_settings();
        set_window(16'd0, 16'hFFFF);
        poll(1'b1, 16'd100, 16'd0, 16'sd0);
        poll(1'b1, 16'd100, 16'd4100, 16'sd0);
        poll(1'b1, 16'd100, 16'd4199, 16'sd0);
        poll(1'b1, 16'd100, 16'd4200, 16'sd0);
        poll(1'b1, 16'd100, 16'hFFFE, 16'sd0);
        poll(1'b1, 16'd100, 16'hFFFF, 16'sd0);
        set_window(16'd3800, 16'd3800);
        poll(1'b1, 16'd100, 16'd3800, 16'sd0);
        set_window(16'hFFFF, 16'd0);
        poll(1'b1, 16'd100, 16'd3800, 16'sd0);
        poll(1'b1, 16'd100, 16'hFFFF, 16'sd0);
        set_window(16'd3700, 16'd3701);
        poll(1'b1, 16'd100, 16'd3700, 16'sd0);
        poll(1'b1, 16'd100, 16'd3701, 16'sd0);
        wait_for_reports();
        write_window_reg(RegSpareA, 16'd0);
        write_window_reg(RegSpareB, 16'hFFFF);
        poll(1'b1, 16'd100, 16'd3700, 16'sd0);
        poll(1'b1, 16'd100, 16'd3699, 16'sd0);
        set_window(16'd3000, 16'd4050);
    endtask

    // Long receiver hold-off fills the pipe, then a full pause
    task automatic test_backpressure();
        int n;
        idle_en = 1'b0;
        hold_off_req = 80;
        for (n = 0; n < 30; n++)
            send_poll(random_poll());
        wait_for_reports();
        for (n = 0; n < 10; n++)
            send_poll(random_poll());
        wait_for_reports();
    endtask

    // Random polls over a series of window settings, idling on and off
    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++)
        begin
            random_window();
            idle_en = (phase % 3 != 2);
            for (n = 0; n < RandomPolls / 8; n++)
                send_poll(random_poll());
        end
    endtask

    // Closing stretch with neither side idling
    task automatic test_full_rate();
        int n;
        set_window(16'd3000, 16'd4050);
        idle_en = 1'b0;
        for (n = 0; n < 200; n++)
            send_poll(random_poll());
        wait_for_reports();
    endtask

    // Check each report transfer and drive the receiver stall
    initial
    begin : report_sink
        charge_report_t want;
        int             stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none actual pct %0d",
                             $time, charge_percent);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("charge_percent", want.pct, charge_percent);
                    check_field("held_voltage_mv", want.mv, held_voltage_mv);
                    check_field("held_current_ma", want.cur, held_current_ma);
                    check_field("is_charging", want.chg, is_charging);
                    check_field("changed_event", want.evt, changed_event);
                end
            end
            if (hold_off_req > 0)
            begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            else if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        read_ok         = 1'b0;
        gauge_percent   = 16'd0;
        cell_voltage_mv = 16'd0;
        cell_current_ma = 16'sd0;
        out_stall       = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = bce_pkg::REG_FALLBACK_LOW;
        cfg_data        = 16'd0;
        window_low      = 16'd3000;
        window_high     = 16'd4050;
        held_mv         = 16'd0;
        held_ma         = 16'sd0;
        held_chg        = 1'b0;
        mismatch_count  = 0;
        idle_en         = 1'b1;
        hold_off_req    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_window_settings();
        test_backpressure();
        test_random();
        test_full_rate();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
